// ===== sv/header_list_token_matcher_unit_assert.svh =====
// Assertion macros shared by the verification files of the token matcher.
// Every macro samples on clk and is switched off while arst_n is low.
`ifndef HEADER_LIST_TOKEN_MATCHER_UNIT_ASSERT_SVH
`define HEADER_LIST_TOKEN_MATCHER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge.
`define HLTM_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define HLTM_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/hltm_pkg.sv =====
package hltm_pkg;

	localparam int MAX_TOKEN_LEN = 16;
	localparam int LEN_W = 5;
	localparam int CHARS_W = 8 * MAX_TOKEN_LEN;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 2;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TOKEN_LOW = 2'd0,
		REG_TOKEN_HIGH = 2'd1,
		REG_TOKEN_LENGTH = 2'd2,
		REG_CASE_SENSITIVE = 2'd3
	} reg_index_t;

	// Element scan phase.
	typedef enum logic [3:0] {
		PH_LEAD = 4'b0001,
		PH_MATCH = 4'b0010,
		PH_TRAIL = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [CHARS_W-1:0] chars;
		logic [LEN_W-1:0] length;
		logic case_sensitive;
	} cfg_t;

	typedef struct packed {
		logic value_matched;
		logic header_matched;
	} result_t;

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic cs);
		logic [7:0] r;
		r = c;
		if (!cs && c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic logic is_lws(input logic [7:0] c);
		return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
	endfunction

endpackage

// ===== sv/hltm_scan.sv =====
module hltm_scan import hltm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic step,
	input logic [7:0] value_byte,
	input logic last_in_value,
	input logic last_in_header,
	output result_t result
);

	phase_t phase_q, phase_n;
	logic [LEN_W-1:0] pos_q, pos_n;
	logic value_hit_q, value_hit_n;
	logic header_hit_q, header_hit_n;

	logic [7:0] c;
	logic [LEN_W-1:0] cmp_pos;
	logic [LEN_W-1:0] pos_inc;
	logic [LEN_W-1:0] eff_len;
	logic [7:0] tok_char;
	logic char_hit;
	phase_t phase_b;
	logic [LEN_W-1:0] pos_b;
	logic value_hit_b;
	logic value_final;
	logic header_final;

	always_comb begin
		c = fold_char(value_byte, cfg.case_sensitive);
		if (cfg.length == '0) begin
			eff_len = LEN_W'(1);
		end else if (cfg.length > LEN_W'(MAX_TOKEN_LEN)) begin
			eff_len = LEN_W'(MAX_TOKEN_LEN);
		end else begin
			eff_len = cfg.length;
		end
		// The first non-blank byte of an element always compares against character zero.
		cmp_pos = (phase_q == PH_LEAD) ? '0 : pos_q;
		tok_char = fold_char(cfg.chars[{cmp_pos[3:0], 3'b000} +: 8], cfg.case_sensitive);
		char_hit = (c == tok_char);
		pos_inc = cmp_pos + LEN_W'(1);
	end

	always_comb begin
		phase_b = phase_q;
		pos_b = pos_q;
		value_hit_b = value_hit_q;
		if (c == CHAR_COMMA) begin
			if (phase_q == PH_TRAIL) begin
				value_hit_b = 1'b1;
			end
			phase_b = PH_LEAD;
			pos_b = '0;
		end else begin
			unique case (phase_q) inside
				PH_LEAD, PH_MATCH: begin
					if (phase_q == PH_MATCH || !is_lws(c)) begin
						if (char_hit) begin
							pos_b = pos_inc;
							phase_b = (pos_inc >= eff_len) ? PH_TRAIL : PH_MATCH;
						end else begin
							pos_b = cmp_pos;
							phase_b = PH_SKIP;
						end
					end
				end
				PH_TRAIL: begin
					if (!is_lws(c)) begin
						phase_b = PH_SKIP;
					end
				end
				PH_SKIP: begin
				end
				default: begin
					phase_b = PH_SKIP;
				end
			endcase
		end

		// A value that ends right after a full match counts as a hit.
		value_final = value_hit_b | (phase_b == PH_TRAIL);
		header_final = header_hit_q | value_final;

		if (last_in_value) begin
			phase_n = PH_LEAD;
			pos_n = '0;
			value_hit_n = 1'b0;
			header_hit_n = last_in_header ? 1'b0 : header_final;
		end else begin
			phase_n = phase_b;
			pos_n = pos_b;
			value_hit_n = value_hit_b;
			header_hit_n = header_hit_q;
		end
		result.value_matched = value_final;
		result.header_matched = header_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pos_q <= '0;
			value_hit_q <= 1'b0;
			header_hit_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			value_hit_q <= value_hit_n;
			header_hit_q <= header_hit_n;
		end
	end

endmodule

// ===== sv/header_list_token_matcher_unit.sv =====
// Channel   | Direction | tdata                    | tlast          | tuser
// ----------+-----------+--------------------------+----------------+---------------
// s_axis    | in        | [7:0] value_byte         | last_in_value  | last_in_header
// m_axis    | out       | [0] value_matched,       | last           | (none)
//           |           | [1] header_matched, pad  |                |
// cfg       | in        | cfg_wen, cfg_index, cfg_wdata; one register per write
//
// One byte transfer is taken every cycle while input is not stalled. A byte is held
// in the input register and is then scanned against the token in the same cycle
// that it moves on; a closing byte's result goes to the output register. The only
// stall comes from the single output register: while it holds a result that is
// not taken, a closing byte waits in the input register and input stops.
// Reset clears the scan state and the configuration to a one-character token
// of zero with case folding on.
module header_list_token_matcher_unit import hltm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,    // [7:0] value_byte
	input logic s_tlast,          // last_in_value
	input logic s_tuser,          // last_in_header
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,   // [0] value_matched, [1] header_matched, [7:2] zero
	output logic m_tlast,         // last
	input logic cfg_wen,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] tok_low_q;
	logic [CFG_DATA_W-1:0] tok_high_q;
	logic [LEN_W-1:0] tok_len_q;
	logic case_sens_q;
	cfg_t cfg;

	// Input register.
	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_value_s1;
	logic last_header_s1;

	// Output register.
	logic out_valid_q;
	result_t out_res_q;
	logic out_last_q;

	logic out_free;
	logic advance;
	result_t scan_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_low_q <= '0;
			tok_high_q <= '0;
			tok_len_q <= LEN_W'(1);
			case_sens_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (reg_index_t'(cfg_index))
				REG_TOKEN_LOW: tok_low_q <= cfg_wdata;
				REG_TOKEN_HIGH: tok_high_q <= cfg_wdata;
				REG_TOKEN_LENGTH: tok_len_q <= cfg_wdata[LEN_W-1:0];
				REG_CASE_SENSITIVE: case_sens_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.chars = {tok_high_q, tok_low_q};
	assign cfg.length = tok_len_q;
	assign cfg.case_sensitive = case_sens_q;

	// A byte that does not close a value leaves no result, so it never waits.
	assign out_free = !out_valid_q || m_tready;
	assign advance = valid_s1 && (!last_value_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_value_s1 <= s_tlast;
			last_header_s1 <= s_tuser;
		end
	end

	hltm_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(advance),
		.value_byte(byte_s1),
		.last_in_value(last_value_s1),
		.last_in_header(last_header_s1),
		.result(scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_value_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_value_s1) begin
			out_res_q <= scan_res;
			out_last_q <= last_header_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b000000, out_res_q.header_matched, out_res_q.value_matched};
	assign m_tlast = out_last_q;

endmodule

// ===== sv/hltm_monitor.sv =====
`include "header_list_token_matcher_unit_assert.svh"

module hltm_monitor (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [7:0] m_tdata,
	input logic m_tlast
);

	`HLTM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
	`HLTM_ASSERT_ALWAYS(a_pad_zero, !m_tvalid || m_tdata[7:2] == 6'b000000, "tdata padding not zero")
	`HLTM_ASSERT_ALWAYS(a_value_in_header, !(m_tvalid && m_tdata[0]) || m_tdata[1], "value match without header match")
	`HLTM_ASSERT_ALWAYS(a_ready_when_empty, m_tvalid || s_tready, "input stalled with empty output")

endmodule

bind header_list_token_matcher_unit hltm_monitor u_monitor (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

// ===== tb/sv/header_list_token_matcher_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the comma-list token matcher.
// Header value bytes are streamed in one transfer at a time while a scoreboard
// tracks the element scan and predicts the result for every closing byte. Both
// stream sides idle at random, and one long receiver hold-off forces the block
// to back up and stall its input.
module header_list_token_matcher_unit_test;
	import hltm_pkg::*;

	// One predicted result transfer.
	typedef struct {
		bit value_matched;
		bit header_matched;
		bit last;
	} match_result_t;

	// A token length of zero is taken as one and anything above the maximum
	// is clipped, so the scan never needs more than MAX_TOKEN_LEN characters.
	function automatic int token_span(input logic [LEN_W-1:0] len);
		if (len == 0) begin
			return 1;
		end
		if (len > MAX_TOKEN_LEN) begin
			return MAX_TOKEN_LEN;
		end
		return int'(len);
	endfunction

	// Tracks the element scan of the block, queues the result that each
	// closing byte produces and compares it with what the block sends.
	class token_match_scoreboard;
		logic [CHARS_W-1:0] token_chars;
		logic [LEN_W-1:0] token_length;
		bit case_sensitive;
		phase_t phase;
		logic [4:0] match_pos;
		bit value_hit;
		bit header_hit;
		match_result_t pending_results[$];
		int errors;
		int results_seen;

		function new();
			token_chars = '0;
			token_length = 5'd1;
			case_sensitive = 1'b0;
			phase = PH_LEAD;
			match_pos = '0;
			value_hit = 1'b0;
			header_hit = 1'b0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TOKEN_LOW: token_chars[63:0] = data;
				REG_TOKEN_HIGH: token_chars[127:64] = data;
				REG_TOKEN_LENGTH: token_length = data[LEN_W-1:0];
				REG_CASE_SENSITIVE: case_sensitive = data[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] fold(logic [7:0] c);
			if (!case_sensitive && c >= 8'h41 && c <= 8'h5A) begin
				return c + 8'h20;
			end
			return c;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
		endfunction

		// Compares one byte against the token character at the current position.
		function void compare_char(logic [7:0] c);
			logic [7:0] want;
			want = fold(token_chars[int'(match_pos[3:0]) * 8 +: 8]);
			if (c == want) begin
				match_pos = match_pos + 5'd1;
				phase = (int'(match_pos) >= token_span(token_length)) ? PH_TRAIL : PH_MATCH;
			end else begin
				phase = PH_SKIP;
			end
		endfunction

		function void note_input(logic [7:0] raw, bit value_end, bit header_end);
			logic [7:0] c;
			match_result_t res;
			c = fold(raw);
			if (c == CHAR_COMMA) begin
				if (phase == PH_TRAIL) begin
					value_hit = 1'b1;
				end
				phase = PH_LEAD;
				match_pos = '0;
			end else begin
				case (phase)
					PH_LEAD: begin
						if (!is_blank(c)) begin
							match_pos = '0;
							compare_char(c);
						end
					end
					PH_MATCH: compare_char(c);
					PH_TRAIL: begin
						if (!is_blank(c)) begin
							phase = PH_SKIP;
						end
					end
					default: ;
				endcase
			end
			if (!value_end) begin
				return;
			end
			if (phase == PH_TRAIL) begin
				value_hit = 1'b1;
			end
			header_hit = header_hit | value_hit;
			res.value_matched = value_hit;
			res.header_matched = header_hit;
			res.last = header_end;
			pending_results.insert(pending_results.size(), res);
			phase = PH_LEAD;
			match_pos = '0;
			value_hit = 1'b0;
			if (header_end) begin
				header_hit = 1'b0;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
		endtask

		task check_result(logic [7:0] data, logic last);
			match_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result tdata=%h tlast=%b", data, last));
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			if (data[0] !== want.value_matched) begin
				report($sformatf("value_matched %b, expected %b", data[0], want.value_matched));
			end
			if (data[1] !== want.header_matched) begin
				report($sformatf("header_matched %b, expected %b", data[1],
					want.header_matched));
			end
			if (last !== want.last) begin
				report($sformatf("last %b, expected %b", last, want.last));
			end
			if (data[7:2] !== 6'd0) begin
				report($sformatf("padding bits %b are not zero", data[7:2]));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	token_match_scoreboard sb = new();

	// Token currently programmed, kept here so that the stimulus can build
	// elements that hit it, nearly hit it or miss it.
	logic [CHARS_W-1:0] cur_chars;
	int cur_span;
	bit cur_case;

	int bytes_sent;
	int send_burst;
	int recv_burst;
	bit hold_req;

	header_list_token_matcher_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net: a correct run ends well before this point.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Gap length before a transfer. Most gaps are zero or short, a few are long,
	// and now and then a burst of back-to-back transfers is forced.
	function automatic int pick_gap(ref int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			burst = $urandom_range(20, 60);
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 3))
			0: return CHAR_SPACE;
			1: return CHAR_TAB;
			2: return CHAR_CR;
			default: return CHAR_LF;
		endcase
	endfunction

	// Mostly letters of both cases, some digits and other printable bytes.
	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		if (r < 5) begin
			return 8'($urandom_range(8'h41, 8'h5A));
		end
		if (r < 7) begin
			return 8'($urandom_range(8'h30, 8'h39));
		end
		if (r < 8) begin
			return 8'h2D;
		end
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] c);
		bit letter;
		letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		if (letter && $urandom_range(0, 1) == 1) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	// Appends one list element with optional whitespace padding on both sides.
	// The element is the token itself, a prefix, the token with an extra or
	// altered character, a random word or nothing at all.
	function automatic void add_element(ref logic [7:0] q[$]);
		int kind;
		int n;
		int pos;
		logic [7:0] c;
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3)) q.insert(q.size(), blank_char());
		end
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			n = (kind == 4) ? $urandom_range(0, cur_span - 1) : cur_span;
			pos = (kind == 6) ? $urandom_range(0, cur_span - 1) : -1;
			for (int i = 0; i < n; i++) begin
				c = cur_chars[i * 8 +: 8];
				if (!cur_case) begin
					c = flip_case(c);
				end
				q.insert(q.size(), (i == pos) ? word_char() : c);
			end
			if (kind == 5) begin
				q.insert(q.size(), word_char());
			end
		end else if (kind <= 8) begin
			repeat ($urandom_range(1, 6)) q.insert(q.size(), word_char());
		end
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3)) q.insert(q.size(), blank_char());
		end
	endfunction

	// Drives one byte transfer after a random gap and waits until it is taken.
	task send_byte(input logic [7:0] b, input bit value_end, input bit header_end);
		repeat (pick_gap(send_burst)) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= value_end;
		s_tuser <= header_end;
		do @(posedge clk); while (!s_tready);
		sb.note_input(b, value_end, header_end);
		bytes_sent++;
	endtask

	task send_text(input string s, input bit header_end);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == s.len() - 1, header_end && i == s.len() - 1);
		end
	endtask

	// A well-formed header: one to three values, each a comma-separated list.
	task send_header();
		logic [7:0] q[$];
		int nvals;
		bit tail;
		nvals = $urandom_range(1, 3);
		for (int v = 0; v < nvals; v++) begin
			q.delete();
			if ($urandom_range(0, 9) == 0) begin
				q.insert(q.size(), CHAR_COMMA);
			end
			add_element(q);
			repeat ($urandom_range(0, 3)) begin
				q.insert(q.size(), CHAR_COMMA);
				add_element(q);
			end
			if (q.size() == 0) begin
				q.insert(q.size(), blank_char());
			end
			for (int i = 0; i < q.size(); i++) begin
				tail = (i == q.size() - 1);
				send_byte(q[i], tail, tail && v == nvals - 1);
			end
		end
	endtask

	// Arbitrary bytes; the header end flag shows up without a value end too.
	task send_noise();
		send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
			$urandom_range(0, 1) == 1);
	endtask

	// Stops input and lets every expected result drain. A byte that closes
	// nothing may still sit in the block, so the task goes on waiting after
	// the last result before the block counts as idle.
	task settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
	endtask

	task apply_config(input logic [CHARS_W-1:0] chars, input logic [63:0] len_word,
		input logic [63:0] case_word);
		write_reg(REG_TOKEN_LOW, chars[63:0]);
		write_reg(REG_TOKEN_HIGH, chars[127:64]);
		write_reg(REG_TOKEN_LENGTH, len_word);
		write_reg(REG_CASE_SENSITIVE, case_word);
		@(negedge clk);
		cfg_wen <= 1'b0;
		cur_chars = chars;
		cur_span = token_span(len_word[LEN_W-1:0]);
		cur_case = case_word[0];
	endtask

	// Random token of the given length code. Bytes past the token length are
	// random so that every write data bit is exercised. Some tokens start
	// with whitespace or hold a comma; those can never be matched.
	task random_config(input logic [LEN_W-1:0] len, input bit cs);
		logic [CHARS_W-1:0] chars;
		logic [63:0] len_word;
		logic [63:0] case_word;
		int span;
		for (int k = 0; k < 4; k++) begin
			chars[k * 32 +: 32] = $urandom;
		end
		span = token_span(len);
		for (int i = 0; i < span; i++) begin
			chars[i * 8 +: 8] = word_char();
		end
		case ($urandom_range(0, 7))
			0: chars[7:0] = blank_char();
			1: chars[$urandom_range(0, span - 1) * 8 +: 8] = CHAR_COMMA;
			default: ;
		endcase
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len;
		case_word = {$urandom, $urandom};
		case_word[0] = cs;
		apply_config(chars, len_word, case_word);
	endtask

	// Receiver: random stalls, runs of readiness, and on request one long
	// hold-off so that the block fills up and stops taking input.
	initial begin
		m_tready = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (300) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			repeat (pick_gap(recv_burst)) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			repeat (($urandom_range(0, 19) == 0) ? 60 : $urandom_range(1, 8)) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			sb.check_result(m_tdata, m_tlast);
		end
	end

	initial begin
		logic [LEN_W-1:0] len_code;
		int target;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_TOKEN_LOW;
		cfg_wdata = '0;
		cur_chars = '0;
		cur_span = 1;
		cur_case = 1'b0;
		bytes_sent = 0;
		send_burst = 0;
		recv_burst = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// After reset the token is a single NUL byte with case folding on.
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
		settle();

		// Token "AB" under folding, padded with whitespace in the data. A header
		// end flag without a value end must be ignored.
		apply_config({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_4241}, 64'd2, 64'd0);
		send_text(" ab\t,x", 1'b0);
		send_byte(8'h61, 1'b0, 1'b1);
		send_byte(8'h42, 1'b1, 1'b1);
		settle();

		// A length of zero acts as one; exact case comparison.
		apply_config({64'd0, 64'h5A}, 64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_byte(8'h7A, 1'b1, 1'b0);
		send_byte(8'h5A, 1'b1, 1'b1);
		settle();

		// A token that starts with whitespace can never match.
		apply_config({64'd0, 64'h6120}, 64'd2, 64'd0);
		send_text(" a", 1'b1);
		settle();

		// A token holding a comma can never match either.
		apply_config({64'd0, 64'h622C61}, 64'd3, 64'd1);
		send_text("a,b", 1'b1);
		settle();

		// Random phases, each with its own token. The first ones cover the
		// longest token, the shortest, and lengths above the maximum and zero.
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: len_code = 5'd16;
				1: len_code = 5'd1;
				2: len_code = 5'd31;
				3: len_code = 5'd17;
				4: len_code = 5'd0;
				default: len_code = ($urandom_range(0, 3) == 0) ?
					5'($urandom_range(9, 16)) : 5'($urandom_range(1, 8));
			endcase
			random_config(len_code, (p < 4) ? p[0] : $urandom_range(0, 1) == 1);
			if (p == 2) begin
				hold_req = 1'b1;
			end
			target = bytes_sent + 70;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 99) < 85) begin
					send_header();
				end else begin
					repeat ($urandom_range(1, 6)) send_noise();
				end
			end
			// Close any open header so the next token starts from a clean scan.
			send_byte(CHAR_SPACE, 1'b1, 1'b1);
			settle();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== header_list_token_matcher_unit.f =====
+incdir+sv
sv/hltm_pkg.sv
sv/hltm_scan.sv
sv/header_list_token_matcher_unit.sv
sv/hltm_monitor.sv
tb/sv/header_list_token_matcher_unit_test.sv
